[hw/rtl/bfa_pkg.sv]
// bfa_pkg: shared types and constants of the bitmap frame allocator
// no dependencies; used by bitmap_frame_allocator

package bfa_pkg;

  // default sizing of the frame pool
  localparam int FRAME_COUNT_DEF = 256;
  localparam int PAGE_BYTES_DEF  = 4096;

  // one map word of used bits per memory entry
  localparam int WORD_BITS = 32;

  // operation codes on the input tuser
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes on the output tuser
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_FREE_RD,
    S_FREE_WR
  } bfa_state_t;

endpackage

[hw/rtl/bfa_ram.sv]
// bfa_ram: generic single-clock ram, one write and one read port,
// registered read data; no dependencies

module bfa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bitmap_frame_allocator.sv]
// bitmap_frame_allocator: first-fit frame allocator over a used-bit map
// depends on bfa_pkg and bfa_ram
//
//  channel  | direction | tdata                                    | tuser
//  ---------+-----------+------------------------------------------+-----------
//  in_      | slave     | [31:0] free_address                      | [1:0] operation
//  out_     | master    | [31:0] frame_address, [39:32] frame_index| [1:0] status
//  cfg_     | write     | cfg_wr_data = pool_base                  | -
//
// the map sits in one ram of 32-bit words (W = ceil(FRAME_COUNT/32) words).
// allocate reads one word per cycle through the ram port.
// free in range divides by the page size with one reciprocal multiply, then a
// read-modify-write; out of range or code 3 is answered from idle without the ram.
// clear sweeps the ram one word per cycle; after reset the same sweep runs
// with in_tready low.
// an item is taken while idle and the result register is empty or draining.

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] free_address
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] frame_address, [39:32] frame_index
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int WORDS     = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW        = $clog2(FRAME_COUNT);
  localparam int LAST_BITS = FRAME_COUNT - (WORDS - 1) * WORD_BITS;

  // reciprocal of the page size, exact for every offset below the pool span
  localparam longint unsigned SPAN_L  = 64'(FRAME_COUNT) * 64'(PAGE_BYTES);
  localparam int              OW      = $clog2(SPAN_L);
  localparam int              PW      = $clog2(PAGE_BYTES);
  localparam int              RSH     = OW + PW;
  localparam int              RW      = OW + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

  localparam logic [AW-1:0]   LAST_WORD = AW'(WORDS - 1);
  localparam logic [31:0]     LAST_MASK = 32'hFFFF_FFFF >> (WORD_BITS - LAST_BITS);
  localparam logic [32:0]     SPAN      = 33'(SPAN_L);
  localparam logic [31:0]     PAGE32    = 32'(PAGE_BYTES);
  localparam logic [RW-1:0]   RECIP     = RW'(RECIP_L);

  bfa_state_t state_r, state_nxt;

  logic [31:0]   pool_base_r, pool_base_nxt;
  logic [AW-1:0] word_r, word_nxt;
  logic          pend_clr_r, pend_clr_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [IW-1:0] quo_r, quo_nxt;

  logic          out_tvalid_r, out_tvalid_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic [7:0]    out_idx_r, out_idx_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic             accept;
  logic [1:0]       in_op;
  logic [32:0]      offset;
  logic             out_of_range;
  logic [31:0]      scan_mask;
  logic [31:0]      avail;
  logic             found;
  logic [4:0]       found_bit;
  logic [31:0]      alloc_idx;
  logic [31:0]      free_idx;
  logic [OW+RW-1:0] prod;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign in_op     = in_tuser;

  // compare without wrap: borrow means below the base
  assign offset       = {1'b0, in_tdata} - {1'b0, pool_base_r};
  assign out_of_range = offset[32] || (offset >= SPAN);

  assign scan_mask = (word_r == LAST_WORD) ? LAST_MASK : 32'hFFFF_FFFF;
  assign avail     = ~ram_rdata & scan_mask;

  always_comb begin
    found     = 1'b0;
    found_bit = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        found_bit = 5'(i);
      end
    end
  end

  assign alloc_idx = (32'(word_r) << 5) | 32'(found_bit);
  assign free_idx  = 32'(quo_r);
  assign prod      = (OW+RW)'(off_r) * (OW+RW)'(RECIP);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (word_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ALLOC: state_nxt = S_SCAN;
            OP_FREE:  state_nxt = out_of_range ? S_IDLE : S_DIV;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (found || word_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:     state_nxt = S_FREE_RD;
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pool_base_nxt  = cfg_wr_en ? cfg_wr_data : pool_base_r;
    word_nxt       = word_r;
    pend_clr_nxt   = pend_clr_r;
    off_nxt        = off_r;
    quo_nxt        = quo_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_idx_nxt    = out_idx_r;
    out_st_nxt     = out_st_r;
    ram_we         = 1'b0;
    ram_waddr      = word_r;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        word_nxt = word_r + AW'(1);
        if (word_r == LAST_WORD) begin
          word_nxt     = '0;
          pend_clr_nxt = 1'b0;
          if (pend_clr_r) begin
            out_tvalid_nxt = 1'b1;
            out_addr_nxt   = '0;
            out_idx_nxt    = '0;
            out_st_nxt     = STAT_OK;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          word_nxt = '0;
          off_nxt  = offset[OW-1:0];
          quo_nxt  = '0;
          case (in_op)
            OP_ALLOC: begin
              ram_raddr = '0;
            end
            OP_FREE: begin
              if (out_of_range) begin
                out_tvalid_nxt = 1'b1;
                out_addr_nxt   = '0;
                out_idx_nxt    = '0;
                out_st_nxt     = STAT_RANGE;
              end
            end
            OP_CLEAR: begin
              pend_clr_nxt = 1'b1;
            end
            default: begin
              out_tvalid_nxt = 1'b1;
              out_addr_nxt   = '0;
              out_idx_nxt    = '0;
              out_st_nxt     = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // fetch the next word while this one is checked
        if (word_r != LAST_WORD) begin
          ram_raddr = word_r + AW'(1);
        end
        if (found) begin
          ram_we         = 1'b1;
          ram_waddr      = word_r;
          ram_wdata      = ram_rdata | (32'd1 << found_bit);
          out_tvalid_nxt = 1'b1;
          out_addr_nxt   = pool_base_r + 32'(alloc_idx * PAGE32);
          out_idx_nxt    = alloc_idx[7:0];
          out_st_nxt     = STAT_OK;
        end else if (word_r == LAST_WORD) begin
          out_tvalid_nxt = 1'b1;
          out_addr_nxt   = '0;
          out_idx_nxt    = '0;
          out_st_nxt     = STAT_EXHAUSTED;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      S_DIV: begin
        // frame index = offset / page size by reciprocal multiply
        quo_nxt = prod[RSH +: IW];
      end
      S_FREE_RD: begin
        ram_raddr = free_idx[5 +: AW];
      end
      S_FREE_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = free_idx[5 +: AW];
        ram_wdata      = ram_rdata & ~(32'd1 << free_idx[4:0]);
        out_tvalid_nxt = 1'b1;
        out_addr_nxt   = '0;
        out_idx_nxt    = free_idx[7:0];
        out_st_nxt     = STAT_OK;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      word_r       <= '0;
      pend_clr_r   <= 1'b0;
      pool_base_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_r       <= word_nxt;
      pend_clr_r   <= pend_clr_nxt;
      pool_base_r  <= pool_base_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    quo_r      <= quo_nxt;
    out_addr_r <= out_addr_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_idx_r, out_addr_r};
  assign out_tuser  = out_st_r;

endmodule
